>>> rtl/exptok_pkg.sv
// ----------------------------------------------------------------------------
// exptok_pkg
// Shared types, token codes and byte classes for the expression tokenizer.
// ----------------------------------------------------------------------------
package exptok_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int MAX_RECS    = 3;
    localparam logic [2:0] KW_LEN = 3'd5;

    localparam logic [3:0] TT_PRINT   = 4'd0;
    localparam logic [3:0] TT_IDENT   = 4'd1;
    localparam logic [3:0] TT_NUMBER  = 4'd2;
    localparam logic [3:0] TT_STRING  = 4'd3;
    localparam logic [3:0] TT_LPAREN  = 4'd4;
    localparam logic [3:0] TT_RPAREN  = 4'd5;
    localparam logic [3:0] TT_EQUAL   = 4'd6;
    localparam logic [3:0] TT_PLUS    = 4'd7;
    localparam logic [3:0] TT_MINUS   = 4'd8;
    localparam logic [3:0] TT_STAR    = 4'd9;
    localparam logic [3:0] TT_SLASH   = 4'd10;
    localparam logic [3:0] TT_UNKNOWN = 4'd11;
    localparam logic [3:0] TT_END     = 4'd12;

    localparam logic REC_TEXT  = 1'b0;
    localparam logic REC_CLOSE = 1'b1;

    localparam logic ACT_CHAR = 1'b0;
    localparam logic ACT_EOS  = 1'b1;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_EQUAL  = 8'h3d;
    localparam logic [7:0] CH_PLUS   = 8'h2b;
    localparam logic [7:0] CH_MINUS  = 8'h2d;
    localparam logic [7:0] CH_STAR   = 8'h2a;
    localparam logic [7:0] CH_SLASH  = 8'h2f;

    typedef struct packed {
        logic       action;
        logic [7:0] char_code;
    } source_t;

    typedef struct packed {
        logic       record_kind;
        logic [3:0] token_type;
        logic [7:0] text_char;
        logic       last_result;
    } result_t;

    // one record without its last flag
    typedef struct packed {
        logic       kind;
        logic [3:0] ttype;
        logic [7:0] text;
    } rec_t;

    // all records caused by one source beat
    typedef struct packed {
        rec_t [MAX_RECS-1:0] recs;
        logic [1:0]          count;
    } bundle_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5a) || (c >= 8'h61 && c <= 8'h7a);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c == 8'h20 || (c >= 8'h09 && c <= 8'h0d);
    endfunction

    function automatic logic [7:0] kw_char(input logic [2:0] k);
        case (k)
            3'd0:    return 8'h70; // p
            3'd1:    return 8'h72; // r
            3'd2:    return 8'h69; // i
            3'd3:    return 8'h6e; // n
            3'd4:    return 8'h74; // t
            default: return 8'h00;
        endcase
    endfunction

    function automatic logic [3:0] punct_type(input logic [7:0] c);
        case (c)
            CH_LPAREN: return TT_LPAREN;
            CH_RPAREN: return TT_RPAREN;
            CH_EQUAL:  return TT_EQUAL;
            CH_PLUS:   return TT_PLUS;
            CH_MINUS:  return TT_MINUS;
            CH_STAR:   return TT_STAR;
            CH_SLASH:  return TT_SLASH;
            default:   return TT_UNKNOWN;
        endcase
    endfunction

    function automatic rec_t mk_text(input logic [7:0] c);
        rec_t r;
        r.kind  = REC_TEXT;
        r.ttype = TT_PRINT;
        r.text  = c;
        return r;
    endfunction

    function automatic rec_t mk_close(input logic [3:0] t);
        rec_t r;
        r.kind  = REC_CLOSE;
        r.ttype = t;
        r.text  = 8'h00;
        return r;
    endfunction

endpackage

>>> rtl/exptok_front.sv
// ----------------------------------------------------------------------------
// exptok_front
// Classifies each source beat against the scan mode and builds the bundle
// of up to three records that it causes.
// ----------------------------------------------------------------------------
module exptok_front
    import exptok_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      accept,
    input  source_t   source,
    output logic      bundle_valid,
    output bundle_t   bundle
);

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_IDENT,
        MODE_NUMBER,
        MODE_STRING
    } mode_t;

    mode_t      mode_reg, mode_next;
    logic [2:0] kc_reg, kc_next;
    logic       km_reg, km_next;

    logic [7:0] c;
    logic [1:0] n;
    logic       do_idle;
    logic [3:0] open_type;

    assign c = source.char_code;

    always_comb
    begin
        case (mode_reg)
            MODE_IDENT:  open_type = (km_reg && kc_reg == KW_LEN) ? TT_PRINT : TT_IDENT;
            MODE_NUMBER: open_type = TT_NUMBER;
            default:     open_type = TT_STRING;
        endcase
    end

    always_comb
    begin
        mode_next   = mode_reg;
        kc_next     = kc_reg;
        km_next     = km_reg;
        n           = 2'd0;
        do_idle     = 1'b0;
        bundle.recs = '0;

        if (source.action == ACT_EOS)
        begin
            if (mode_reg != MODE_IDLE)
            begin
                bundle.recs[n] = mk_close(open_type);
                n = n + 2'd1;
            end
            mode_next = MODE_IDLE;
            kc_next   = 3'd0;
            km_next   = 1'b0;
            bundle.recs[n] = mk_close(TT_END);
            n = n + 2'd1;
        end
        else
        begin
            case (mode_reg)
                MODE_IDENT:
                begin
                    if (is_alpha(c) || is_digit(c))
                    begin
                        bundle.recs[n] = mk_text(c);
                        n = n + 2'd1;
                        if (km_reg && kc_reg < KW_LEN && c == kw_char(kc_reg))
                            kc_next = kc_reg + 3'd1;
                        else
                            km_next = 1'b0;
                    end
                    else
                    begin
                        bundle.recs[n] = mk_close(open_type);
                        n = n + 2'd1;
                        do_idle = 1'b1;
                    end
                end
                MODE_NUMBER:
                begin
                    if (is_digit(c))
                    begin
                        bundle.recs[n] = mk_text(c);
                        n = n + 2'd1;
                    end
                    else
                    begin
                        bundle.recs[n] = mk_close(open_type);
                        n = n + 2'd1;
                        do_idle = 1'b1;
                    end
                end
                MODE_STRING:
                begin
                    if (c == CH_QUOTE || c == CH_NUL)
                    begin
                        bundle.recs[n] = mk_close(TT_STRING);
                        n = n + 2'd1;
                        mode_next = MODE_IDLE;
                        kc_next   = 3'd0;
                        km_next   = 1'b0;
                    end
                    else
                    begin
                        bundle.recs[n] = mk_text(c);
                        n = n + 2'd1;
                    end
                end
                default:
                begin
                    do_idle = 1'b1;
                end
            endcase

            // the terminator of an open token is handled afresh as in idle
            if (do_idle)
            begin
                mode_next = MODE_IDLE;
                kc_next   = 3'd0;
                km_next   = 1'b0;
                if (is_space(c))
                begin
                    // drop
                end
                else if (is_alpha(c))
                begin
                    bundle.recs[n] = mk_text(c);
                    n = n + 2'd1;
                    mode_next = MODE_IDENT;
                    kc_next   = (c == kw_char(3'd0)) ? 3'd1 : 3'd0;
                    km_next   = (c == kw_char(3'd0));
                end
                else if (is_digit(c))
                begin
                    bundle.recs[n] = mk_text(c);
                    n = n + 2'd1;
                    mode_next = MODE_NUMBER;
                end
                else if (c == CH_QUOTE)
                begin
                    mode_next = MODE_STRING;
                end
                else
                begin
                    bundle.recs[n] = mk_text(c);
                    n = n + 2'd1;
                    bundle.recs[n] = mk_close(punct_type(c));
                    n = n + 2'd1;
                end
            end
        end

        bundle.count = n;
    end

    assign bundle_valid = accept && (n != 2'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_IDLE;
            kc_reg   <= 3'd0;
            km_reg   <= 1'b0;
        end
        else if (accept)
        begin
            mode_reg <= mode_next;
            kc_reg   <= kc_next;
            km_reg   <= km_next;
        end
    end

endmodule

>>> rtl/exptok_queue.sv
// ----------------------------------------------------------------------------
// exptok_queue
// Short register queue of record bundles between the front and back parts.
// ----------------------------------------------------------------------------
module exptok_queue
    import exptok_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      wr_en,
    input  bundle_t   wr_data,
    input  logic      rd_en,
    output bundle_t   rd_data,
    output q_status_t status
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    bundle_t       mem_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          do_wr, do_rd;

    assign status.full  = (cnt_reg == FULL_CNT);
    assign status.empty = (cnt_reg == '0);
    assign do_wr = wr_en && !status.full;
    assign do_rd = rd_en && !status.empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_wr)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + AW'(1);
        if (do_rd)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + AW'(1);
        if (do_wr && !do_rd)
            cnt_next = cnt_reg + CW'(1);
        else if (do_rd && !do_wr)
            cnt_next = cnt_reg - CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

>>> rtl/exptok_back.sv
// ----------------------------------------------------------------------------
// exptok_back
// Walks the head bundle one record per result beat and marks the last one.
// ----------------------------------------------------------------------------
module exptok_back
    import exptok_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  bundle_t   head,
    input  q_status_t q_status,
    input  logic      pop,
    output logic      empty,
    output result_t   result,
    output logic      head_done
);

    logic [1:0] idx_reg, idx_next;
    logic       is_last;
    rec_t       cur;

    assign cur     = head.recs[idx_reg];
    assign is_last = (idx_reg == head.count - 2'd1);
    assign empty   = q_status.empty;

    assign result.record_kind = cur.kind;
    assign result.token_type  = cur.ttype;
    assign result.text_char   = cur.text;
    assign result.last_result = is_last;

    // release the bundle once its last record leaves
    assign head_done = pop && !q_status.empty && is_last;

    always_comb
    begin
        idx_next = idx_reg;
        if (pop && !q_status.empty)
            idx_next = is_last ? 2'd0 : idx_reg + 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idx_reg <= 2'd0;
        else
            idx_reg <= idx_next;
    end

endmodule

>>> rtl/expression_tokenizer_top.sv
// ----------------------------------------------------------------------------
// expression_tokenizer_top
// Streaming lexer: source bytes in, token text and close records out.
//
//   channel  | handshake   | payload
//   ---------+-------------+------------------------------------------
//   source   | push / full | source_t: action, char_code
//   result   | empty / pop | result_t: record_kind, token_type,
//            |             |           text_char, last_result
//
// A source beat is classified in the cycle it is accepted and its records
// (zero to three) are queued as one bundle; one source beat per cycle while
// full is low. The result side moves one record per cycle while pop is high
// and empty is low, so sustained throughput is set by the records per byte.
// full rises when the bundle queue (QueueDepth entries) holds no free slot.
// Reset clears the scan mode, keyword tracking and queue pointers.
// ----------------------------------------------------------------------------
module expression_tokenizer_top
    import exptok_pkg::*;
#(
    parameter int QueueDepth = QUEUE_DEPTH
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    output logic    full,
    input  source_t source,
    output logic    empty,
    input  logic    pop,
    output result_t result
);

    logic      accept;
    logic      bundle_valid;
    bundle_t   bundle;
    bundle_t   head;
    q_status_t q_status;
    logic      head_done;

    assign full   = q_status.full;
    assign accept = push && !q_status.full;

    exptok_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .source       (source),
        .bundle_valid (bundle_valid),
        .bundle       (bundle)
    );

    exptok_queue #(
        .DEPTH (QueueDepth)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (bundle_valid),
        .wr_data (bundle),
        .rd_en   (head_done),
        .rd_data (head),
        .status  (q_status)
    );

    exptok_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .q_status  (q_status),
        .pop       (pop),
        .empty     (empty),
        .result    (result),
        .head_done (head_done)
    );

endmodule
